/* design/scc_pkg.sv */
// scc_pkg: constants, register indexes and transfer structs for the
// segment/circle collision test; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;
    localparam int TOL_BITS   = 16;
    localparam int RAD_BITS   = COORD_BITS - 1;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int Q_W        = SUM_W + 2;
    localparam int HALF_W     = COORD_BITS + 4;
    localparam int MUL_W      = 2 * HALF_W;
    localparam int TOL_RESET  = ((1 << FRAC_BITS) + 5) / 10;

    localparam int CFG_ADDR_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_END_X   = 3'd2,
        REG_END_Y   = 3'd3,
        REG_TOL     = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_ENDPOINT = 2'd1,
        KIND_INTERIOR = 2'd2
    } hit_kind_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic        [RAD_BITS-1:0]   radius;
    } in_item_t;

    typedef struct packed {
        logic      hit;
        hit_kind_t hit_kind;
    } out_item_t;

endpackage
`default_nettype wire

/* design/scc_mul.sv */
// scc_mul: two-stage unsigned multiplier built from four half-width
// partial products; depends on scc_pkg
`timescale 1ns / 1ps
`default_nettype none
module scc_mul
    import scc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic [MUL_W-1:0]     a,
    input  wire logic [MUL_W-1:0]     b,
    output logic      [2*MUL_W-1:0]   p
);

    logic [2*HALF_W-1:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic [2*MUL_W-1:0]  p_reg;
    logic [2*MUL_W-1:0]  p_next;

    // partial products
    always_ff @(posedge clk)
    begin
        ll_reg <= a[HALF_W-1:0]     * b[HALF_W-1:0];
        lh_reg <= a[HALF_W-1:0]     * b[MUL_W-1:HALF_W];
        hl_reg <= a[MUL_W-1:HALF_W] * b[HALF_W-1:0];
        hh_reg <= a[MUL_W-1:HALF_W] * b[MUL_W-1:HALF_W];
    end

    // recombine
    always_comb
    begin
        p_next = (2*MUL_W)'(ll_reg)
               + ((2*MUL_W)'(lh_reg) << HALF_W)
               + ((2*MUL_W)'(hl_reg) << HALF_W)
               + ((2*MUL_W)'(hh_reg) << MUL_W);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule
`default_nettype wire

/* design/segment_circle_collision_top.sv */
// segment_circle_collision_top: pipelined segment versus circle hit test
// depends on scc_pkg and scc_mul
//
//  channel  | signals                          | transfer
//  ---------+----------------------------------+-------------------------------
//  config   | cfg_we, cfg_addr, cfg_wdata      | edge with cfg_we high
//  item     | start, busy, item                | edge with start high, busy low
//  result   | done, result                     | edge with done high
//
// an item passes diff, product, sum, compare, wide-product and result regs;
// one item per cycle, busy is never raised as the pipeline has no stalls.
// the depth is set by the two-stage wide multipliers on the final squared
// compares. reset clears the valid bits and loads the register defaults.
// the receiver cannot stall, so every stage advances on every clock.
`timescale 1ns / 1ps
`default_nettype none
module segment_circle_collision_top
    import scc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [COORD_BITS-1:0] cfg_wdata,
    input  wire logic                  start,
    output logic                       busy,
    input  wire in_item_t              item,
    output logic                       done,
    output out_item_t                  result
);

    // configuration registers
    logic signed [COORD_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic        [TOL_BITS-1:0]   tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg  <= '0;
            sy_reg  <= '0;
            ex_reg  <= '0;
            ey_reg  <= '0;
            tol_reg <= TOL_BITS'(TOL_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_START_X: sx_reg  <= cfg_wdata;
                REG_START_Y: sy_reg  <= cfg_wdata;
                REG_END_X:   ex_reg  <= cfg_wdata;
                REG_END_Y:   ey_reg  <= cfg_wdata;
                REG_TOL:     tol_reg <= cfg_wdata[TOL_BITS-1:0];
                default:     ;
            endcase
        end
    end

    assign busy = 1'b0;

    // valid bits
    logic [7:1] v_reg;
    logic       accept;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[6:1], accept};
    end

    // stage 1: differences
    logic signed [DIFF_W-1:0] ax_reg, ay_reg, ux_reg, uy_reg, bx_reg, by_reg;
    logic        [RAD_BITS-1:0] r_reg;

    always_ff @(posedge clk)
    begin
        ax_reg <= DIFF_W'(item.center_x) - DIFF_W'(sx_reg);
        ay_reg <= DIFF_W'(item.center_y) - DIFF_W'(sy_reg);
        ux_reg <= DIFF_W'(item.center_x) - DIFF_W'(ex_reg);
        uy_reg <= DIFF_W'(item.center_y) - DIFF_W'(ey_reg);
        bx_reg <= DIFF_W'(ex_reg) - DIFF_W'(sx_reg);
        by_reg <= DIFF_W'(ey_reg) - DIFF_W'(sy_reg);
        r_reg  <= item.radius;
    end

    // stage 2: narrow products
    logic signed [PROD_W-1:0] axx_reg, ayy_reg, uxx_reg, uyy_reg, bxx_reg, byy_reg;
    logic signed [PROD_W-1:0] axbx_reg, ayby_reg, axby_reg, aybx_reg;
    logic        [2*RAD_BITS-1:0] rr_reg;

    always_ff @(posedge clk)
    begin
        axx_reg  <= ax_reg * ax_reg;
        ayy_reg  <= ay_reg * ay_reg;
        uxx_reg  <= ux_reg * ux_reg;
        uyy_reg  <= uy_reg * uy_reg;
        bxx_reg  <= bx_reg * bx_reg;
        byy_reg  <= by_reg * by_reg;
        axbx_reg <= ax_reg * bx_reg;
        ayby_reg <= ay_reg * by_reg;
        axby_reg <= ax_reg * by_reg;
        aybx_reg <= ay_reg * bx_reg;
        rr_reg   <= r_reg * r_reg;
    end

    // stage 3: sums
    logic signed [SUM_W-1:0] da_reg, du_reg, l2_reg, dot_reg, cr_reg, r2_reg;

    always_ff @(posedge clk)
    begin
        da_reg  <= SUM_W'(axx_reg) + SUM_W'(ayy_reg);
        du_reg  <= SUM_W'(uxx_reg) + SUM_W'(uyy_reg);
        l2_reg  <= SUM_W'(bxx_reg) + SUM_W'(byy_reg);
        dot_reg <= SUM_W'(axbx_reg) + SUM_W'(ayby_reg);
        cr_reg  <= SUM_W'(axby_reg) - SUM_W'(aybx_reg);
        r2_reg  <= $signed(SUM_W'(rr_reg));
    end

    // stage 4: endpoint test, distance from the segment range, magnitudes
    logic signed [Q_W-1:0] e_s, qa_s, m_s;
    logic        [SUM_W-1:0] cra_s;

    always_comb
    begin
        e_s   = Q_W'(dot_reg) + Q_W'(dot_reg) - Q_W'(l2_reg);
        qa_s  = e_s[Q_W-1] ? -e_s : e_s;
        m_s   = qa_s - Q_W'(l2_reg);
        cra_s = cr_reg[SUM_W-1] ? $unsigned(-cr_reg) : $unsigned(cr_reg);
    end

    logic                 ep_reg, nz_reg, mpos_reg;
    logic [MUL_W-1:0]     m_reg, cra_reg, l2m_reg, r2m_reg, t2_reg;

    always_ff @(posedge clk)
    begin
        ep_reg   <= (da_reg <= r2_reg) || (du_reg <= r2_reg);
        nz_reg   <= (l2_reg != '0);
        mpos_reg <= !m_s[Q_W-1] && (m_s != '0);
        m_reg    <= MUL_W'($unsigned(m_s));
        cra_reg  <= MUL_W'(cra_s);
        l2m_reg  <= MUL_W'($unsigned(l2_reg));
        r2m_reg  <= MUL_W'($unsigned(r2_reg));
        t2_reg   <= MUL_W'(tol_reg) * MUL_W'(tol_reg);
    end

    // stages 5 and 6: wide products
    logic [2*MUL_W-1:0] mm, tl, cc, rl;

    scc_mul u_mul_mm (.clk(clk), .a(m_reg),   .b(m_reg),   .p(mm));
    scc_mul u_mul_tl (.clk(clk), .a(t2_reg),  .b(l2m_reg), .p(tl));
    scc_mul u_mul_cc (.clk(clk), .a(cra_reg), .b(cra_reg), .p(cc));
    scc_mul u_mul_rl (.clk(clk), .a(r2m_reg), .b(l2m_reg), .p(rl));

    logic [2:1] ep_d_reg, nz_d_reg, mpos_d_reg;

    always_ff @(posedge clk)
    begin
        ep_d_reg   <= {ep_d_reg[1],   ep_reg};
        nz_d_reg   <= {nz_d_reg[1],   nz_reg};
        mpos_d_reg <= {mpos_d_reg[1], mpos_reg};
    end

    // stage 7: final compares and result register
    logic      on_seg;
    out_item_t res_next;
    out_item_t res_reg;

    always_comb
    begin
        on_seg = !mpos_d_reg[2] || (mm <= tl);
        if (ep_d_reg[2])
            res_next.hit_kind = KIND_ENDPOINT;
        else if (nz_d_reg[2] && on_seg && (cc <= rl))
            res_next.hit_kind = KIND_INTERIOR;
        else
            res_next.hit_kind = KIND_NONE;
        res_next.hit = (res_next.hit_kind != KIND_NONE);
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = v_reg[7];
    assign result = res_reg;

endmodule
`default_nettype wire

/* tb/scc_checker.sv */
// scc_checker: predicts the segment/circle hit answer for every accepted item
// and compares it with each result transfer; depends on scc_pkg
`timescale 1ns / 1ps
module scc_checker
    import scc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [COORD_BITS-1:0] cfg_wdata,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire in_item_t              item,
    input  wire logic                  done,
    input  wire out_item_t             result,
    output int                         fail_count,
    output int                         pending
);

    // shadow copy of the segment registers
    logic signed [63:0] sx, sy, ex, ey;
    logic [15:0]        tol;
    out_item_t          expected_hits[$];

    assign pending = expected_hits.size();

    function automatic out_item_t predict_hit(in_item_t it);
        logic signed [191:0] ax, ay, bx, by, ux, uy, r, r2, l2, dot, q, m, t, cr;
        out_item_t res;
        ax = $signed(it.center_x) - sx;
        ay = $signed(it.center_y) - sy;
        bx = ex - sx;
        by = ey - sy;
        ux = $signed(it.center_x) - ex;
        uy = $signed(it.center_y) - ey;
        r  = {169'd0, it.radius};
        r2 = r * r;
        res.hit_kind = KIND_NONE;
        // endpoint inside circle
        if (ax * ax + ay * ay <= r2 || ux * ux + uy * uy <= r2)
        begin
            res.hit_kind = KIND_ENDPOINT;
        end
        else
        begin
            l2 = bx * bx + by * by;
            if (l2 != 0)
            begin
                // distance-sum test in squared form
                dot = ax * bx + ay * by;
                q = 2 * dot - l2;
                if (q < 0)
                    q = -q;
                m = q - l2;
                t = {176'd0, tol};
                if (m <= 0 || m * m <= t * t * l2)
                begin
                    cr = ax * by - ay * bx;
                    if (cr * cr <= r2 * l2)
                        res.hit_kind = KIND_INTERIOR;
                end
            end
        end
        res.hit = (res.hit_kind != KIND_NONE);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx = 0; sy = 0; ex = 0; ey = 0;
            tol = TOL_BITS'(TOL_RESET);
            fail_count = 0;
            expected_hits.delete();
        end
        else
        begin
            out_item_t got, want;
            // result transfer against oldest expectation
            if (done)
            begin
                got = result;
                if (expected_hits.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (got.hit !== want.hit)
                    begin
                        $error("hit: expected %0d actual %0d", want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.hit_kind !== want.hit_kind)
                    begin
                        $error("hit_kind: expected %0d actual %0d",
                               want.hit_kind, got.hit_kind);
                        fail_count++;
                    end
                end
            end
            // item transfer
            if (start && !busy)
                expected_hits.push_back(predict_hit(item));
            // register write
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_START_X: sx = $signed(cfg_wdata);
                    REG_START_Y: sy = $signed(cfg_wdata);
                    REG_END_X:   ex = $signed(cfg_wdata);
                    REG_END_Y:   ey = $signed(cfg_wdata);
                    REG_TOL:     tol = cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* tb/tb.sv */
// tb: stimulus and verdict for segment_circle_collision_top
// depends on scc_pkg, scc_checker and the block itself
`timescale 1ns / 1ps
module tb
    import scc_pkg::*;
();

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  cfg_we = 0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [COORD_BITS-1:0] cfg_wdata = '0;
    logic                  start = 0;
    logic                  busy;
    in_item_t              item = '0;
    logic                  done;
    out_item_t             result;
    int                    fail_count, pending;
    int                    gap_pct;
    longint                cycles = 0;

    always #10 clk = ~clk;

    segment_circle_collision_top dut (.*);
    scc_checker chk (.*);

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("segment_circle_collision_top regression: fail");
            $finish;
        end
    end

    function automatic logic [23:0] rand_coord(int spread);
        case ($urandom_range(0, 9))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'($urandom);
            default: return 24'($signed($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
        @(negedge clk);
        cfg_we = 1; cfg_addr = idx; cfg_wdata = val;
        @(negedge clk);
        cfg_we = 0;
    endtask

    // idle the block so registers can change safely
    task automatic drain();
        start = 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_segment(logic [23:0] ax, ay, bx, by, logic [15:0] t);
        drain();
        write_reg(REG_START_X, ax);
        write_reg(REG_START_Y, ay);
        write_reg(REG_END_X, bx);
        write_reg(REG_END_Y, by);
        write_reg(REG_TOL, {8'd0, t});
    endtask

    // one item transfer; start stays high between back-to-back items
    task automatic send_circle(logic [23:0] cx, cy, logic [22:0] r);
        while (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            start = 0;
            @(negedge clk);
        end
        start = 1;
        item.center_x = cx; item.center_y = cy; item.radius = r;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int spread;
        logic [23:0] a, b;
        gap_pct = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // zero-length segment at reset values
        send_circle(24'd0, 24'd0, 23'd0);
        send_circle(24'd1000, 24'd0, 23'd999);
        send_circle(24'h800000, 24'h800000, 23'h7fffff);
        send_circle(24'h7fffff, 24'h7fffff, 23'h7fffff);
        // horizontal segment, interior hits and tolerance edges
        set_segment(24'd0, 24'd0, 24'd2560, 24'd0, 16'd26);
        send_circle(24'd1280, 24'd512, 23'd512);
        send_circle(24'd1280, 24'd512, 23'd511);
        send_circle(24'd1280, -24'sd300, 23'd400);
        send_circle(24'd2600, 24'd100, 23'd120);
        send_circle(24'd3000, 24'd10, 23'd50);
        send_circle(-24'sd256, 24'd0, 23'd256);
        send_circle(24'd2560, 24'd0, 23'd0);
        send_circle(24'd1280, 24'd0, 23'd0);
        set_segment(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 16'hffff);
        send_circle(24'd0, 24'd0, 23'd0);
        send_circle(24'd0, 24'h7fffff, 23'h7fffff);
        send_circle(24'h7fffff, 24'h800000, 23'd1);
        set_segment(24'd100, 24'd100, 24'd100, 24'd100, 16'd0);
        send_circle(24'd100, 24'd100, 23'd0);
        send_circle(24'd300, 24'd100, 23'd199);
        send_circle(24'd300, 24'd100, 23'd200);

        // random phases: sender gaps of 34, then 45, then none
        for (int ph = 0; ph < 12; ph++)
        begin
            spread = (ph % 3 == 0) ? 8000 : (ph % 3 == 1) ? 200000 : 8388607;
            a = rand_coord(spread); b = rand_coord(spread);
            set_segment(a, b, (ph == 5) ? a : rand_coord(spread),
                        (ph == 5) ? b : rand_coord(spread),
                        (ph == 3) ? 16'hffff : (ph == 4) ? 16'd0 : 16'($urandom));
            gap_pct = (ph < 4) ? 34 : (ph < 8) ? 45 : 0;
            for (int i = 0; i < 80; i++)
                send_circle(rand_coord(spread), rand_coord(spread),
                            ($urandom_range(0, 9) == 0) ? 23'($urandom) :
                            23'($urandom_range(0, spread / 2)));
        end

        drain();
        if (fail_count == 0)
            $display("segment_circle_collision_top regression: pass");
        else
            $display("segment_circle_collision_top regression: fail");
        $finish;
    end

endmodule

/* files.f */
design/scc_pkg.sv
design/scc_mul.sv
design/segment_circle_collision_top.sv
tb/scc_checker.sv
tb/tb.sv
